// ===== rtl/core/bpts_pkg.sv =====
// bpts_pkg: shared types and constants of the bitmap priority task scheduler
// payload structs, action codes, controller states and datapath commands
// no dependencies
`default_nettype none

package bpts_pkg;

   localparam int unsigned NUM_PRI_DEF = 16;
   localparam int unsigned PRI_W       = 5;
   localparam int unsigned STACK_SLOTS = 16;
   localparam int unsigned STACK_IDX_W = 4;
   localparam logic [PRI_W-1:0] IDLE_PRI = 5'd16;

   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 64;
   localparam logic REG_READY_AT_START = 1'b0;
   localparam logic REG_EXEC_TABLE     = 1'b1;
   localparam logic [15:0] READY_AT_START_RST = 16'h0000;
   localparam logic [63:0] EXEC_TABLE_RST     = 64'hFEDC_BA98_7654_3210;

   typedef enum logic [2:0] {
      ACT_INIT     = 3'd0,
      ACT_ACTIVATE = 3'd1,
      ACT_QUEUE    = 3'd2,
      ACT_DISPATCH = 3'd3,
      ACT_EXIT     = 3'd4,
      ACT_DISABLE  = 3'd5,
      ACT_ENABLE   = 3'd6
   } action_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic exec;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [2:0] action;
      logic [3:0] priority_req;
   } req_payload_type;

   typedef struct packed {
      logic [4:0] running_priority;
      logic [4:0] current_priority;
      logic       dispatch_request;
      logic       task_started;
      logic       was_dormant;
   } rsp_payload_type;

   typedef struct packed {
      logic [PRI_W-1:0] cur_pri;
      logic [PRI_W-1:0] start_pri;
   } pair_type;

endpackage

`default_nettype wire

// ===== rtl/core/bpts_ctrl.sv =====
// bpts_ctrl: controller of the scheduler, accept and execute sequencing
// owns the result valid flag and issues load/exec commands to the datapath
// depends on bpts_pkg
`default_nettype none

module bpts_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output bpts_pkg::ctrl_cmd_type     cmd
);

   bpts_pkg::ctrl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bpts_pkg::ST_IDLE: begin
            if (req_valid) state_in = bpts_pkg::ST_EXEC;
         end
         bpts_pkg::ST_EXEC: begin
            if (out_free) state_in = bpts_pkg::ST_IDLE;
         end
         default: state_in = bpts_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.load     = 1'b0;
      cmd.exec     = 1'b0;
      req_stall    = 1'b0;
      unique case (state_ff)
         bpts_pkg::ST_IDLE: begin
            cmd.load = req_valid;
         end
         bpts_pkg::ST_EXEC: begin
            req_stall = 1'b1;
            cmd.exec  = out_free;
         end
         default: req_stall = 1'b1;
      endcase
      rsp_valid_in = cmd.exec || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bpts_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_valid_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.exec))
      else $error("result valid rose without an execute step");

endmodule

`default_nettype wire

// ===== rtl/core/bpts_dpath.sv =====
// bpts_dpath: scheduler datapath with ready/pending maps, running priorities,
// the preemption stack, the lowest-bit encoder and the result register
// depends on bpts_pkg, driven by bpts_ctrl commands
`default_nettype none

module bpts_dpath #(
   parameter int unsigned NUM_PRI = bpts_pkg::NUM_PRI_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire bpts_pkg::ctrl_cmd_type  cmd,
   input  wire bpts_pkg::req_payload_type req_payload,
   input  wire logic [15:0]             ready_at_start,
   input  wire logic [63:0]             exec_table,
   output bpts_pkg::rsp_payload_type    rsp_payload
);

   localparam int unsigned PW    = bpts_pkg::PRI_W;
   localparam int unsigned IDX_W = bpts_pkg::STACK_IDX_W;
   localparam logic [PW-1:0] IDLE = bpts_pkg::IDLE_PRI;

   logic [NUM_PRI-1:0] ready_ff, ready_in, pending_ff, pending_in;
   logic [PW-1:0] run_start_ff, run_start_in, run_cur_ff, run_cur_in;
   logic [PW-1:0] depth_ff, depth_in, depth_m1;
   logic dispatch_off_ff, dispatch_off_in;

   bpts_pkg::pair_type saved_mem [bpts_pkg::STACK_SLOTS];
   bpts_pkg::pair_type top_ff, push_pair;
   bpts_pkg::req_payload_type item_ff;
   bpts_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic [NUM_PRI-1:0] req_bit, run_bit, exit_ready, enc_in;
   logic [3:0] enc_idx;
   logic enc_any;
   logic [PW-1:0] enc_pri, next_cur, sv_start, sv_cur;
   logic req_ok, dormant, dreq, started, push_en;

   assign req_ok     = {1'b0, item_ff.priority_req} < PW'(NUM_PRI);
   assign req_bit    = NUM_PRI'(1) << item_ff.priority_req;
   assign run_bit    = NUM_PRI'(1) << run_start_ff[3:0];
   assign exit_ready = (ready_ff & ~run_bit) | (pending_ff & run_bit);
   assign enc_in     = (item_ff.action == bpts_pkg::ACT_EXIT) ? exit_ready : ready_ff;
   assign dormant    = (ready_ff & req_bit) == '0;
   assign depth_m1   = depth_ff - PW'(1);

   // lowest set bit
   always_comb begin
      enc_idx = '0;
      for (int i = NUM_PRI - 1; i >= 0; i--) begin
         if (enc_in[i]) enc_idx = 4'(i);
      end
      enc_any = |enc_in;
   end

   assign enc_pri  = {1'b0, enc_idx};
   assign next_cur = {1'b0, exec_table[{enc_idx, 2'b00} +: 4]};
   assign sv_start = (depth_ff != '0) ? top_ff.start_pri : IDLE;
   assign sv_cur   = (depth_ff != '0) ? top_ff.cur_pri : IDLE;

   assign push_pair.start_pri = run_start_ff;
   assign push_pair.cur_pri   = run_cur_ff;

   always_comb begin
      ready_in        = ready_ff;
      pending_in      = pending_ff;
      run_start_in    = run_start_ff;
      run_cur_in      = run_cur_ff;
      depth_in        = depth_ff;
      dispatch_off_in = dispatch_off_ff;
      dreq            = 1'b0;
      started         = 1'b0;
      push_en         = 1'b0;
      unique case (bpts_pkg::action_type'(item_ff.action))
         bpts_pkg::ACT_INIT: begin
            ready_in        = ready_at_start[NUM_PRI-1:0];
            pending_in      = '0;
            run_start_in    = IDLE;
            run_cur_in      = IDLE;
            dispatch_off_in = 1'b0;
            depth_in        = '0;
         end
         bpts_pkg::ACT_ACTIVATE: begin
            if (req_ok) begin
               ready_in = ready_ff | req_bit;
               if (({1'b0, item_ff.priority_req} < run_cur_ff) && !dispatch_off_ff) begin
                  dreq = 1'b1;
               end
            end
         end
         bpts_pkg::ACT_QUEUE: begin
            pending_in = pending_ff | req_bit;
         end
         bpts_pkg::ACT_DISPATCH: begin
            if (!dispatch_off_ff && enc_any && (depth_ff < PW'(bpts_pkg::STACK_SLOTS))
                && (enc_pri < run_cur_ff)) begin
               push_en      = 1'b1;
               depth_in     = depth_ff + PW'(1);
               run_start_in = enc_pri;
               run_cur_in   = next_cur;
               started      = 1'b1;
            end
         end
         bpts_pkg::ACT_EXIT: begin
            if (run_start_ff < IDLE) begin
               dispatch_off_in = 1'b0;
               ready_in        = exit_ready;
               pending_in      = pending_ff & ~run_bit;
               if (enc_any && (enc_pri < sv_cur)) begin
                  run_start_in = enc_pri;
                  run_cur_in   = next_cur;
                  started      = 1'b1;
               end else begin
                  run_start_in = sv_start;
                  run_cur_in   = sv_cur;
                  if (depth_ff != '0) depth_in = depth_m1;
               end
            end
         end
         bpts_pkg::ACT_DISABLE: dispatch_off_in = 1'b1;
         bpts_pkg::ACT_ENABLE:  dispatch_off_in = 1'b0;
         default: ;
      endcase
      rsp_in.running_priority = run_start_in;
      rsp_in.current_priority = run_cur_in;
      rsp_in.dispatch_request = dreq;
      rsp_in.task_started     = started;
      rsp_in.was_dormant      = dormant;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff        <= '0;
         pending_ff      <= '0;
         run_start_ff    <= IDLE;
         run_cur_ff      <= IDLE;
         depth_ff        <= '0;
         dispatch_off_ff <= 1'b0;
      end else if (cmd.exec) begin
         ready_ff        <= ready_in;
         pending_ff      <= pending_in;
         run_start_ff    <= run_start_in;
         run_cur_ff      <= run_cur_in;
         depth_ff        <= depth_in;
         dispatch_off_ff <= dispatch_off_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) item_ff <= req_payload;
      if (cmd.exec) rsp_ff <= rsp_in;
   end

   // preemption stack, top entry read into a register ahead of its use
   always_ff @(posedge clock) begin
      if (cmd.exec && push_en) saved_mem[depth_ff[IDX_W-1:0]] <= push_pair;
      top_ff <= saved_mem[depth_m1[IDX_W-1:0]];
   end

   assign rsp_payload = rsp_ff;

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= PW'(bpts_pkg::STACK_SLOTS))
      else $error("stack depth beyond its slots");

   a_idle_pair: assert property (@(posedge clock) disable iff (reset)
      (run_start_ff == IDLE) == (run_cur_ff == IDLE))
      else $error("start and current priority disagree on idle");

   a_push_depth: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && push_en |=> depth_ff == $past(depth_ff) + PW'(1))
      else $error("preemption did not grow the stack");

endmodule

`default_nettype wire

// ===== rtl/core/bitmap_priority_task_scheduler.sv =====
// bitmap_priority_task_scheduler: top level with the configuration registers
// joins bpts_ctrl and bpts_dpath; depends on bpts_pkg
//
// usage:
//   req channel (req_valid, req_stall, req_payload) carries one kernel action
//   with its priority; rsp channel (rsp_valid, rsp_stall, rsp_payload) returns
//   one result per action: running and current priority, dispatch request,
//   task start and the dormancy of the queried priority.
//   configuration registers sit on the apb-style port: ready_at_start at
//   byte address 0, execution priority table at 8 (64-bit data, pready tied
//   high); write them only while no action is in flight.
//   an accepted action is captured, then executed in the controller's execute
//   step, where the result register and valid flag load; no new action is
//   taken until that execute step is done.
//   a stalled result holds the controller in its execute step; one further
//   action can be captured meanwhile, then req_stall stays high.
//   reset: maps cleared, running task idle (16), stack empty, dispatch enabled,
//   configuration registers at their defaults; no clearing pass is needed.
`default_nettype none

module bitmap_priority_task_scheduler #(
   parameter int unsigned NUM_PRI = bpts_pkg::NUM_PRI_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire bpts_pkg::req_payload_type         req_payload,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output bpts_pkg::rsp_payload_type              rsp_payload,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [bpts_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [bpts_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [bpts_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                   pready
);

   logic [15:0] ready_at_start_ff;
   logic [63:0] exec_table_ff;
   logic        csr_write;
   bpts_pkg::ctrl_cmd_type cmd;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_at_start_ff <= bpts_pkg::READY_AT_START_RST;
         exec_table_ff     <= bpts_pkg::EXEC_TABLE_RST;
      end else if (csr_write) begin
         unique case (paddr[3])
            bpts_pkg::REG_READY_AT_START: ready_at_start_ff <= pwdata[15:0];
            bpts_pkg::REG_EXEC_TABLE:     exec_table_ff     <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3])
         bpts_pkg::REG_READY_AT_START: prdata = {48'b0, ready_at_start_ff};
         bpts_pkg::REG_EXEC_TABLE:     prdata = exec_table_ff;
         default:                      prdata = '0;
      endcase
   end

   bpts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   bpts_dpath #(
      .NUM_PRI (NUM_PRI)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_payload    (req_payload),
      .ready_at_start (ready_at_start_ff),
      .exec_table     (exec_table_ff),
      .rsp_payload    (rsp_payload)
   );

endmodule

`default_nettype wire

// ===== test/bitmap_priority_task_scheduler_tb.sv =====
// bitmap_priority_task_scheduler_tb: self-checking bench for the priority task scheduler
// directed table, then randomized action streams checked against a scheduling predictor
// depends on bpts_pkg and bitmap_priority_task_scheduler
module bitmap_priority_task_scheduler_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] ACT_NOP = 3'd7;
   localparam int HOLD_CYCLES = 80;
   localparam int PHASE_ITEMS = 175;
   localparam int PRESSURE_ITEMS = 30;

   typedef struct packed {
      logic [2:0]                action;
      logic [3:0]                pri;
      logic                      typed;
      bpts_pkg::rsp_payload_type rsp;
   } directed_row_type;

   typedef struct packed {
      logic                      typed;
      bpts_pkg::rsp_payload_type rsp;
   } check_entry_type;

   logic                                clock;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   bpts_pkg::req_payload_type           req_payload = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   bpts_pkg::rsp_payload_type           rsp_payload;
   logic                                psel = 1'b0;
   logic                                penable = 1'b0;
   logic                                pwrite = 1'b0;
   logic [bpts_pkg::CSR_ADDR_W-1:0]     paddr = '0;
   logic [bpts_pkg::CSR_DATA_W-1:0]     pwdata = '0;
   logic [bpts_pkg::CSR_DATA_W-1:0]     prdata;
   logic                                pready;

   bit quiet = 1'b0;
   bit pressure = 1'b0;
   bit long_hold_due = 1'b0;
   int error_count = 0;

   // scheduler state and register copies
   logic [15:0] cfg_ready_start = bpts_pkg::READY_AT_START_RST;
   logic [63:0] cfg_exec_table = bpts_pkg::EXEC_TABLE_RST;
   logic [15:0] ready_map = '0;
   logic [15:0] pending_map = '0;
   logic [4:0]  run_start = bpts_pkg::IDLE_PRI;
   logic [4:0]  run_cur = bpts_pkg::IDLE_PRI;
   logic        dispatch_off = 1'b0;
   bpts_pkg::pair_type saved_pairs [bpts_pkg::STACK_SLOTS];
   logic [4:0]  stack_depth = '0;

   check_entry_type           pending_checks [$];
   bpts_pkg::rsp_payload_type expected_results [$];

   directed_row_type directed_rows [23] = '{
      {bpts_pkg::ACT_EXIT,     4'd0,  1'b1, 5'd16, 5'd16, 1'b0, 1'b0, 1'b1},
      {bpts_pkg::ACT_DISPATCH, 4'd0,  1'b1, 5'd16, 5'd16, 1'b0, 1'b0, 1'b1},
      {bpts_pkg::ACT_INIT,     4'd15, 1'b1, 5'd16, 5'd16, 1'b0, 1'b0, 1'b1},
      {bpts_pkg::ACT_ACTIVATE, 4'd15, 1'b1, 5'd16, 5'd16, 1'b1, 1'b0, 1'b0},
      {bpts_pkg::ACT_DISPATCH, 4'd0,  1'b1, 5'd0,  5'd0,  1'b0, 1'b1, 1'b0},
      {bpts_pkg::ACT_ACTIVATE, 4'd0,  1'b1, 5'd0,  5'd0,  1'b0, 1'b0, 1'b0},
      {bpts_pkg::ACT_QUEUE,    4'd0,  1'b1, 5'd0,  5'd0,  1'b0, 1'b0, 1'b0},
      {bpts_pkg::ACT_EXIT,     4'd0,  1'b1, 5'd0,  5'd0,  1'b0, 1'b1, 1'b0},
      {bpts_pkg::ACT_EXIT,     4'd15, 1'b1, 5'd15, 5'd15, 1'b0, 1'b1, 1'b0},
      {bpts_pkg::ACT_DISABLE,  4'd3,  1'b1, 5'd15, 5'd15, 1'b0, 1'b0, 1'b1},
      {bpts_pkg::ACT_ACTIVATE, 4'd3,  1'b1, 5'd15, 5'd15, 1'b0, 1'b0, 1'b1},
      {bpts_pkg::ACT_DISPATCH, 4'd3,  1'b1, 5'd15, 5'd15, 1'b0, 1'b0, 1'b0},
      {bpts_pkg::ACT_ENABLE,   4'd3,  1'b1, 5'd15, 5'd15, 1'b0, 1'b0, 1'b0},
      {bpts_pkg::ACT_DISPATCH, 4'd3,  1'b0, 13'd0},
      {ACT_NOP,                4'd9,  1'b1, 5'd3,  5'd3,  1'b0, 1'b0, 1'b1},
      {bpts_pkg::ACT_EXIT,     4'd3,  1'b0, 13'd0},
      {bpts_pkg::ACT_EXIT,     4'd15, 1'b1, 5'd16, 5'd16, 1'b0, 1'b0, 1'b0},
      {bpts_pkg::ACT_EXIT,     4'd15, 1'b1, 5'd16, 5'd16, 1'b0, 1'b0, 1'b1},
      {bpts_pkg::ACT_QUEUE,    4'd15, 1'b1, 5'd16, 5'd16, 1'b0, 1'b0, 1'b1},
      {bpts_pkg::ACT_ACTIVATE, 4'd15, 1'b1, 5'd16, 5'd16, 1'b1, 1'b0, 1'b1},
      {bpts_pkg::ACT_DISPATCH, 4'd15, 1'b1, 5'd15, 5'd15, 1'b0, 1'b1, 1'b0},
      {bpts_pkg::ACT_EXIT,     4'd15, 1'b0, 13'd0},
      {bpts_pkg::ACT_INIT,     4'd0,  1'b1, 5'd16, 5'd16, 1'b0, 1'b0, 1'b1}
   };

   bitmap_priority_task_scheduler u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s at %0t: got %0h expected %0h", what, $time, got, want);
      error_count++;
   endtask

   function automatic logic [4:0] lowest_ready(input logic [15:0] map);
      logic [4:0] n;
      n = bpts_pkg::IDLE_PRI;
      for (int i = 15; i >= 0; i--) begin
         if (map[i]) n = 5'(i);
      end
      return n;
   endfunction

   function automatic logic [4:0] exec_of(input logic [4:0] pri);
      return {1'b0, cfg_exec_table[{pri[3:0], 2'b00} +: 4]};
   endfunction

   function automatic bpts_pkg::rsp_payload_type schedule_action(
      input bpts_pkg::req_payload_type p);
      bpts_pkg::rsp_payload_type r;
      logic [15:0]     req_bit;
      logic [15:0]     run_bit;
      logic [4:0]      nxt;
      logic [4:0]      sv_start;
      logic [4:0]      sv_cur;
      logic            chained;
      req_bit = 16'd1 << p.priority_req;
      r = '0;
      r.was_dormant = ((ready_map & req_bit) == 16'd0);
      unique case (p.action)
         bpts_pkg::ACT_INIT: begin
            ready_map = cfg_ready_start;
            pending_map = '0;
            run_start = bpts_pkg::IDLE_PRI;
            run_cur = bpts_pkg::IDLE_PRI;
            dispatch_off = 1'b0;
            stack_depth = '0;
         end
         bpts_pkg::ACT_ACTIVATE: begin
            ready_map |= req_bit;
            if ({1'b0, p.priority_req} < run_cur && !dispatch_off) r.dispatch_request = 1'b1;
         end
         bpts_pkg::ACT_QUEUE: begin
            pending_map |= req_bit;
         end
         bpts_pkg::ACT_DISPATCH: begin
            if (!dispatch_off && ready_map != 16'd0
                && stack_depth < bpts_pkg::STACK_SLOTS) begin
               nxt = lowest_ready(ready_map);
               if (nxt < run_cur) begin
                  saved_pairs[stack_depth[3:0]].start_pri = run_start;
                  saved_pairs[stack_depth[3:0]].cur_pri = run_cur;
                  stack_depth++;
                  run_start = nxt;
                  run_cur = exec_of(nxt);
                  r.task_started = 1'b1;
               end
            end
         end
         bpts_pkg::ACT_EXIT: begin
            if (run_start < bpts_pkg::IDLE_PRI) begin
               run_bit = 16'd1 << run_start[3:0];
               sv_start = bpts_pkg::IDLE_PRI;
               sv_cur = bpts_pkg::IDLE_PRI;
               chained = 1'b0;
               if (stack_depth != 5'd0) begin
                  sv_start = saved_pairs[4'(stack_depth - 5'd1)].start_pri;
                  sv_cur = saved_pairs[4'(stack_depth - 5'd1)].cur_pri;
               end
               dispatch_off = 1'b0;
               ready_map &= ~run_bit;
               if ((pending_map & run_bit) != 16'd0) begin
                  pending_map &= ~run_bit;
                  ready_map |= run_bit;
               end
               if (ready_map != 16'd0) begin
                  nxt = lowest_ready(ready_map);
                  if (nxt < sv_cur) begin
                     run_start = nxt;
                     run_cur = exec_of(nxt);
                     r.task_started = 1'b1;
                     chained = 1'b1;
                  end
               end
               if (!chained) begin
                  run_start = sv_start;
                  run_cur = sv_cur;
                  if (stack_depth != 5'd0) stack_depth--;
               end
            end
         end
         bpts_pkg::ACT_DISABLE: begin
            dispatch_off = 1'b1;
         end
         bpts_pkg::ACT_ENABLE: begin
            dispatch_off = 1'b0;
         end
         default: begin
         end
      endcase
      r.running_priority = run_start;
      r.current_priority = run_cur;
      return r;
   endfunction

   // transfer tracking on both channels
   always @(posedge clock) begin
      check_entry_type           entry;
      bpts_pkg::rsp_payload_type predicted;
      bpts_pkg::rsp_payload_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            entry = pending_checks.pop_front();
            predicted = schedule_action(req_payload);
            expected_results.push_back(entry.typed ? entry.rsp : predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", 64'(rsp_payload), '0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_payload.running_priority !== want.running_priority)
                  report_mismatch("running_priority", 64'(rsp_payload.running_priority),
                                  64'(want.running_priority));
               if (rsp_payload.current_priority !== want.current_priority)
                  report_mismatch("current_priority", 64'(rsp_payload.current_priority),
                                  64'(want.current_priority));
               if (rsp_payload.dispatch_request !== want.dispatch_request)
                  report_mismatch("dispatch_request", 64'(rsp_payload.dispatch_request),
                                  64'(want.dispatch_request));
               if (rsp_payload.task_started !== want.task_started)
                  report_mismatch("task_started", 64'(rsp_payload.task_started),
                                  64'(want.task_started));
               if (rsp_payload.was_dormant !== want.was_dormant)
                  report_mismatch("was_dormant", 64'(rsp_payload.was_dormant),
                                  64'(want.was_dormant));
            end
         end
      end
   end

   // result side hold-off
   initial begin
      @(posedge clock);
      forever begin
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (quiet) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            rsp_stall <= 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
      end
   end

   task automatic send_action(input logic [2:0] action, input logic [3:0] pri,
                              input logic typed, input bpts_pkg::rsp_payload_type want);
      int gap;
      gap = (!quiet && !pressure && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
      pending_checks.push_back({typed, want});
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_payload <= {action, pri};
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_checks.size() + expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic reg_index, input logic [63:0] value);
      logic [63:0] want;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_index, 3'b000};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (reg_index == bpts_pkg::REG_READY_AT_START) begin
         cfg_ready_start = value[15:0];
         want = {48'd0, value[15:0]};
      end else begin
         cfg_exec_table = value;
         want = value;
      end
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (reg_index == bpts_pkg::REG_READY_AT_START) begin
         if ({48'd0, prdata[15:0]} !== want) report_mismatch("ready_at_start readback",
                                                              prdata, want);
      end else if (prdata !== want) begin
         report_mismatch("exec_priority_table readback", prdata, want);
      end
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_phase(input logic [15:0] ready_cfg, input logic [63:0] exec_cfg,
                               input bit with_pressure);
      logic [2:0] action;
      int         w;
      drain_results();
      csr_write(bpts_pkg::REG_READY_AT_START, {48'd0, ready_cfg});
      csr_write(bpts_pkg::REG_EXEC_TABLE, exec_cfg);
      send_action(bpts_pkg::ACT_INIT, 4'($urandom_range(0, 15)), 1'b0, '0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         if (with_pressure && i == PHASE_ITEMS / 2) begin
            pressure = 1'b1;
            long_hold_due = 1'b1;
         end
         if (with_pressure && i == PHASE_ITEMS / 2 + PRESSURE_ITEMS) pressure = 1'b0;
         w = $urandom_range(0, 99);
         if (w < 28) action = bpts_pkg::ACT_ACTIVATE;
         else if (w < 52) action = bpts_pkg::ACT_DISPATCH;
         else if (w < 72) action = bpts_pkg::ACT_EXIT;
         else if (w < 82) action = bpts_pkg::ACT_QUEUE;
         else if (w < 88) action = bpts_pkg::ACT_DISABLE;
         else if (w < 94) action = bpts_pkg::ACT_ENABLE;
         else if (w < 97) action = bpts_pkg::ACT_INIT;
         else action = ACT_NOP;
         send_action(action, 4'($urandom_range(0, 15)), 1'b0, '0);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_write(bpts_pkg::REG_READY_AT_START, 64'h8001);
      csr_write(bpts_pkg::REG_EXEC_TABLE, bpts_pkg::EXEC_TABLE_RST);
      foreach (directed_rows[i]) begin
         send_action(directed_rows[i].action, directed_rows[i].pri, directed_rows[i].typed,
                     directed_rows[i].rsp);
      end
      random_phase(16'hFFFF, 64'h0123_4567_89AB_CDEF, 1'b0);
      random_phase(16'h0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      random_phase(16'($urandom), 64'h0, 1'b0);
      random_phase(16'($urandom), {$urandom, $urandom}, 1'b1);
      quiet = 1'b1;
      random_phase(16'h8001, bpts_pkg::EXEC_TABLE_RST, 1'b0);
      drain_results();
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== bitmap_priority_task_scheduler.f =====
rtl/core/bpts_pkg.sv
rtl/core/bpts_ctrl.sv
rtl/core/bpts_dpath.sv
rtl/core/bitmap_priority_task_scheduler.sv
test/bitmap_priority_task_scheduler_tb.sv
